/* src/v3alu_pkg.sv */
// Package for the 3D vector arithmetic unit: opcodes, saturation helper
// and the sideband record that travels beside the root and divide pipelines.
// No dependencies.
package v3alu_pkg;

    // Operation codes carried on req_type.
    localparam logic [3:0] OP_ADD        = 4'd0;
    localparam logic [3:0] OP_SUB        = 4'd1;
    localparam logic [3:0] OP_ADD_SCALAR = 4'd2;
    localparam logic [3:0] OP_SUB_SCALAR = 4'd3;
    localparam logic [3:0] OP_SCALE      = 4'd4;
    localparam logic [3:0] OP_DOT        = 4'd5;
    localparam logic [3:0] OP_CROSS     = 4'd6;
    localparam logic [3:0] OP_NORM2      = 4'd7;
    localparam logic [3:0] OP_NORM       = 4'd8;
    localparam logic [3:0] OP_NORMALISE  = 4'd9;

    // Number of digit stages in the square-root pipeline (one root bit each).
    localparam int SQ_STAGES = 32;

    // Saturated 32-bit value with its overflow mark.
    typedef struct packed {
        logic signed [31:0] val;
        logic               ov;
    } sat_t;

    // Record that follows an item through the root and divide pipelines.
    typedef struct packed {
        logic             vld;
        logic [3:0]       op;
        logic [2:0][31:0] vec;
        logic             vov;
        logic [31:0]      scal;
        logic             sov;
        logic             zero;
        logic [2:0][31:0] a;
        logic [31:0]      nrm;
    } side_t;

    localparam logic signed [65:0] MAX32 = 66'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [65:0] MIN32 = 66'sh3_FFFF_FFFF_8000_0000;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t r;
        r.ov  = 1'b0;
        r.val = v[31:0];
        if (v > MAX32)
        begin
            r.ov  = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end
        else if (v < MIN32)
        begin
            r.ov  = 1'b1;
            r.val = 32'sh8000_0000;
        end
        return r;
    endfunction

endpackage

/* src/v3alu_lane.sv */
// One component lane: two multipliers, the add/subtract path and product
// rounding with saturation. Depends on v3alu_pkg.
module v3alu_lane
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [3:0]         op,
    input  logic signed [31:0] ai,
    input  logic signed [31:0] bi,
    input  logic signed [31:0] aj,
    input  logic signed [31:0] bm,
    input  logic signed [31:0] am,
    input  logic signed [31:0] bj,
    input  logic signed [31:0] k,
    output logic signed [63:0] prod,
    output logic signed [31:0] vec,
    output logic               ov
);

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0] m0a, m0b, oper;
    logic signed [32:0] sum33;
    sat_t               as_sat, rnd_sat;
    logic signed [63:0] p0_reg, p1_reg;
    logic signed [31:0] as_reg;
    logic               asov_reg;
    logic [3:0]         op1_reg;
    logic signed [65:0] diff, rnd;
    logic signed [31:0] vec_next, vec_reg;
    logic               ov_next, ov_reg;

    // Multiplier operand selection.
    always_comb
    begin
        case (op) inside
            OP_SCALE:
            begin
                m0a = ai;
                m0b = k;
            end
            OP_CROSS:
            begin
                m0a = aj;
                m0b = bm;
            end
            OP_NORM2, OP_NORM, OP_NORMALISE:
            begin
                m0a = ai;
                m0b = ai;
            end
            default:
            begin
                m0a = ai;
                m0b = bi;
            end
        endcase
    end

    // Add and subtract against the other vector or the scalar.
    always_comb
    begin
        oper  = (op == OP_ADD || op == OP_SUB) ? bi : k;
        sum33 = (op == OP_SUB || op == OP_SUB_SCALAR) ? (33'(ai) - 33'(oper))
                                                      : (33'(ai) + 33'(oper));
        as_sat = sat32(66'(sum33));
    end

    // First stage: products and saturated sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg <= OP_ADD;
        end
        else if (en)
        begin
            op1_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= m0a * m0b;
            p1_reg   <= am * bj;
            as_reg   <= as_sat.val;
            asov_reg <= as_sat.ov;
        end
    end

    // Second stage: round the product term and pick the lane result.
    always_comb
    begin
        diff    = (op1_reg == OP_CROSS) ? (66'(p0_reg) - 66'(p1_reg)) : 66'(p0_reg);
        rnd     = (diff + HALF) >>> FRAC_BITS;
        rnd_sat = sat32(rnd);
        case (op1_reg) inside
            OP_ADD, OP_SUB, OP_ADD_SCALAR, OP_SUB_SCALAR:
            begin
                vec_next = as_reg;
                ov_next  = asov_reg;
            end
            OP_SCALE, OP_CROSS:
            begin
                vec_next = rnd_sat.val;
                ov_next  = rnd_sat.ov;
            end
            default:
            begin
                vec_next = '0;
                ov_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
            ov_reg  <= ov_next;
        end
    end

    assign prod = p0_reg;
    assign vec  = vec_reg;
    assign ov   = ov_reg;

endmodule

/* src/v3alu_sqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage,
// returning root and remainder. Depends on v3alu_pkg.
module v3alu_sqrt
    import v3alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [63:0] s,
    output logic [31:0] root,
    output logic [32:0] rem
);

    logic [63:0] x_reg [SQ_STAGES];
    logic [63:0] r_reg [SQ_STAGES];

    genvar g;
    generate
        for (g = 0; g < SQ_STAGES; g++)
        begin : g_stage
            logic [63:0] xin, rin, bitv, trial;

            // Trial subtraction of the next root digit.
            always_comb
            begin
                if (g == 0)
                begin
                    xin = s;
                    rin = '0;
                end
                else
                begin
                    xin = x_reg[g-1];
                    rin = r_reg[g-1];
                end
                bitv  = 64'd1 << (62 - 2 * g);
                trial = rin + bitv;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    x_reg[g] <= '0;
                    r_reg[g] <= '0;
                end
                else if (en)
                begin
                    if (xin >= trial)
                    begin
                        x_reg[g] <= xin - trial;
                        r_reg[g] <= (rin >> 1) + bitv;
                    end
                    else
                    begin
                        x_reg[g] <= xin;
                        r_reg[g] <= rin >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = r_reg[SQ_STAGES-1][31:0];
    assign rem  = x_reg[SQ_STAGES-1][32:0];

    // The remainder of a floor root never exceeds twice the root.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem <= {root, 1'b0})
        else $error("square-root remainder out of range");

endmodule

/* src/v3alu_div.sv */
// Pipelined restoring divider for one normalise lane: rounds |a|*2^F / n
// to nearest and restores the sign. Depends on v3alu_pkg.
module v3alu_div
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic [31:0]        n,
    output logic signed [31:0] quo
);

    localparam int QW = FRAC_BITS + 2;
    localparam int DW = FRAC_BITS + 33;

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [31:0]   n_reg   [QW];
    logic          neg_reg [QW];
    logic [31:0]   mag;
    logic [DW-1:0] dividend;

    // Magnitude with half the divisor added for rounding to nearest.
    always_comb
    begin
        mag      = a[31] ? (32'd0 - 32'(a)) : 32'(a);
        dividend = (DW'(mag) << FRAC_BITS) + DW'(n[31:1]);
    end

    genvar g;
    generate
        for (g = 0; g < QW; g++)
        begin : g_stage
            logic [DW-1:0] rin, trial;
            logic [QW-1:0] qin;
            logic [31:0]   nin;
            logic          negin;

            // One quotient bit per stage, most significant first.
            always_comb
            begin
                if (g == 0)
                begin
                    rin   = dividend;
                    qin   = '0;
                    nin   = n;
                    negin = a[31];
                end
                else
                begin
                    rin   = rem_reg[g-1];
                    qin   = q_reg[g-1];
                    nin   = n_reg[g-1];
                    negin = neg_reg[g-1];
                end
                trial = DW'(nin) << (QW - 1 - g);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[g]   <= nin;
                    neg_reg[g] <= negin;
                    if (rin >= trial)
                    begin
                        rem_reg[g] <= rin - trial;
                        q_reg[g]   <= qin | (QW'(1) << (QW - 1 - g));
                    end
                    else
                    begin
                        rem_reg[g] <= rin;
                        q_reg[g]   <= qin;
                    end
                end
            end
        end
    endgenerate

    assign quo = neg_reg[QW-1] ? (32'sd0 - 32'(q_reg[QW-1])) : 32'(q_reg[QW-1]);

endmodule

/* src/v3alu_delay.sv */
// Delay line for the sideband record, one register per stage, advancing
// with the pipeline. Depends on v3alu_pkg.
module v3alu_delay
    import v3alu_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  side_t din,
    output side_t dout
);

    side_t line_reg [DEPTH];

    // Shift the record one stage on each advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

/* src/vector3_alu_top.sv */
// 3D vector arithmetic unit, Q(32-FRAC_BITS).FRAC_BITS fixed point.
// The latency from input transfer to result valid is the same for every
// opcode and is set by the 32-stage root and FRAC_BITS + 2 stage divide
// pipelines. Throughput: one item per cycle; the whole pipeline holds
// while a finished result waits. Reset clears all valid bits; the input,
// lane, divide and output data registers are not reset.
module vector3_alu_top
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         req_type,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scalar_k,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_z,
    output logic signed [31:0] res_scalar,
    output logic               overflow_flag,
    output logic               zero_norm_error
);

    localparam int QW = FRAC_BITS + 2;
    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

    logic               adv;
    logic               vld0_reg, vld1_reg, vld2_reg, out_valid_reg;
    logic [3:0]         op0_reg, op1_reg, op2_reg;
    logic signed [31:0] a0_reg [3];
    logic signed [31:0] b0_reg [3];
    logic signed [31:0] k0_reg;
    logic signed [31:0] a1_reg [3];
    logic signed [31:0] a2_reg [3];
    logic signed [63:0] prod [3];
    logic signed [31:0] lvec [3];
    logic               lov [3];
    logic signed [65:0] sum_reg;
    sat_t               dot_sat;
    side_t              side2, side_d1, side3_next, side3_reg, side_d2;
    logic [31:0]        root;
    logic [32:0]        rem;
    logic signed [31:0] quo [3];
    logic signed [31:0] rx_next, ry_next, rz_next, rs_next;
    logic signed [31:0] rx_reg, ry_reg, rz_reg, rs_reg;
    logic               ov_next, zerr_next, ov_reg, zerr_reg;

    // The pipeline advances unless a result is waiting for its transfer.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Input capture and early control stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld0_reg <= in_valid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg   <= req_type;
            a0_reg[0] <= a_x;
            a0_reg[1] <= a_y;
            a0_reg[2] <= a_z;
            b0_reg[0] <= b_x;
            b0_reg[1] <= b_y;
            b0_reg[2] <= b_z;
            k0_reg    <= scalar_k;
            op1_reg   <= op0_reg;
            op2_reg   <= op1_reg;
            a1_reg    <= a0_reg;
            a2_reg    <= a1_reg;
            sum_reg   <= 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]);
        end
    end

    // Component lanes.
    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (adv),
                .op    (op0_reg),
                .ai    (a0_reg[g]),
                .bi    (b0_reg[g]),
                .aj    (a0_reg[(g + 1) % 3]),
                .bm    (b0_reg[(g + 2) % 3]),
                .am    (a0_reg[(g + 2) % 3]),
                .bj    (b0_reg[(g + 1) % 3]),
                .k     (k0_reg),
                .prod  (prod[g]),
                .vec   (lvec[g]),
                .ov    (lov[g])
            );
        end
    endgenerate

    // Merge the lanes: rounded dot product and the sideband record.
    always_comb
    begin
        dot_sat     = sat32((sum_reg + HALF) >>> FRAC_BITS);
        side2.vld   = vld2_reg;
        side2.op    = op2_reg;
        side2.vec   = {lvec[2], lvec[1], lvec[0]};
        side2.vov   = lov[0] | lov[1] | lov[2];
        side2.scal  = (op2_reg == OP_DOT || op2_reg == OP_NORM2) ? dot_sat.val : '0;
        side2.sov   = (op2_reg == OP_DOT || op2_reg == OP_NORM2) ? dot_sat.ov : 1'b0;
        side2.zero  = (sum_reg == '0);
        side2.a     = {a2_reg[2], a2_reg[1], a2_reg[0]};
        side2.nrm   = '0;
    end

    v3alu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .s     (sum_reg[63:0]),
        .root  (root),
        .rem   (rem)
    );

    v3alu_delay #(.DEPTH(SQ_STAGES)) u_delay_root (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   (side2),
        .dout  (side_d1)
    );

    // Round the root to nearest.
    always_comb
    begin
        side3_next     = side_d1;
        side3_next.nrm = root + 32'(rem > 33'(root));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side3_reg <= '0;
        end
        else if (adv)
        begin
            side3_reg <= side3_next;
        end
    end

    // Normalise dividers, one per component.
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
                .clk (clk),
                .en  (adv),
                .a   (side3_reg.a[g]),
                .n   (side3_reg.nrm),
                .quo (quo[g])
            );
        end
    endgenerate

    v3alu_delay #(.DEPTH(QW)) u_delay_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   (side3_reg),
        .dout  (side_d2)
    );

    // Result selection by opcode.
    always_comb
    begin
        rx_next   = '0;
        ry_next   = '0;
        rz_next   = '0;
        rs_next   = '0;
        ov_next   = 1'b0;
        zerr_next = 1'b0;
        case (side_d2.op) inside
            OP_ADD, OP_SUB, OP_ADD_SCALAR, OP_SUB_SCALAR, OP_SCALE, OP_CROSS:
            begin
                rx_next = side_d2.vec[0];
                ry_next = side_d2.vec[1];
                rz_next = side_d2.vec[2];
                ov_next = side_d2.vov;
            end
            OP_DOT, OP_NORM2:
            begin
                rs_next = side_d2.scal;
                ov_next = side_d2.sov;
            end
            OP_NORM:
            begin
                rs_next = side_d2.nrm[31] ? 32'sh7FFF_FFFF : side_d2.nrm;
                ov_next = side_d2.nrm[31];
            end
            OP_NORMALISE:
            begin
                if (side_d2.zero)
                begin
                    zerr_next = 1'b1;
                end
                else
                begin
                    rx_next = quo[0];
                    ry_next = quo[1];
                    rz_next = quo[2];
                end
            end
            default:
            begin
                rs_next = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= side_d2.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            rz_reg   <= rz_next;
            rs_reg   <= rs_next;
            ov_reg   <= ov_next;
            zerr_reg <= zerr_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign res_x           = rx_reg;
    assign res_y           = ry_reg;
    assign res_z           = rz_reg;
    assign res_scalar      = rs_reg;
    assign overflow_flag   = ov_reg;
    assign zero_norm_error = zerr_reg;

    // A zero-length normalise returns all zeros and no overflow.
    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm_error |-> (res_x == 0 && res_y == 0 && res_z == 0
            && res_scalar == 0 && !overflow_flag))
        else $error("zero-norm result not cleared");

    // With no result waiting the block always takes input.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A waiting result keeps its value until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({res_x, res_y, res_z, res_scalar, overflow_flag, zero_norm_error}))
        else $error("result changed while waiting");

endmodule
